### rtl/csb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants of the cursor sequence buffer.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_ADVANCE = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_ATTACH  = 3'd3,
        ACT_REMOVE  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_CURRENT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift_op;

    typedef struct packed {
        t_shift_op          op;
        logic [IDX_W-1:0]   pos;
    } t_shift_cmd;

    typedef struct packed {
        logic               strobe;
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   cursor;
    } t_result_info;

endpackage
`default_nettype wire

### rtl/csb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csb_cell
// One entry of the buffer; takes its left or right neighbor, or the new value, on a shift.
// ----------------------------------------------------------------------------
module csb_cell (
    input  wire logic                      i_clk,
    input  wire logic [csb_pkg::IDX_W-1:0] i_index,
    input  wire csb_pkg::t_shift_cmd       i_cmd,
    input  wire logic [csb_pkg::WIDTH-1:0] i_value,
    input  wire logic [csb_pkg::WIDTH-1:0] i_left,
    input  wire logic [csb_pkg::WIDTH-1:0] i_right,
    output logic      [csb_pkg::WIDTH-1:0] o_data
);

    logic [csb_pkg::WIDTH-1:0] r_data;
    logic [csb_pkg::WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            csb_pkg::SH_INSERT: begin
                if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.pos) begin
                    n_data = i_value;
                end
            end
            csb_pkg::SH_REMOVE: begin
                if (i_index >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

### rtl/csb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csb_ctrl
// Count and cursor registers; decodes each request into a shift command.
// ----------------------------------------------------------------------------
module csb_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [2:0]                i_action,
    output csb_pkg::t_shift_cmd            o_cmd,
    output csb_pkg::t_result_info          o_info
);

    logic [csb_pkg::CNT_W-1:0] r_count;
    logic [csb_pkg::CNT_W-1:0] n_count;
    logic [csb_pkg::CNT_W-1:0] r_cursor;
    logic [csb_pkg::CNT_W-1:0] n_cursor;
    csb_pkg::t_status          r_status;
    csb_pkg::t_status          n_status;
    logic                      r_strobe;
    logic                      w_has;
    logic                      w_full;
    logic [csb_pkg::CNT_W-1:0] w_next_cur;
    csb_pkg::t_action          w_action;

    assign w_action   = csb_pkg::t_action'(i_action);
    assign w_has      = r_cursor < r_count;
    assign w_full     = r_count == csb_pkg::CNT_W'(csb_pkg::DEPTH);
    assign w_next_cur = r_cursor + csb_pkg::CNT_W'(1);

    always_comb begin
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_status  = csb_pkg::ST_OK;
        o_cmd.op  = csb_pkg::SH_HOLD;
        o_cmd.pos = '0;
        if (i_accept) begin
            unique case (w_action)
                csb_pkg::ACT_START: begin
                    n_cursor = '0;
                end
                csb_pkg::ACT_ADVANCE: begin
                    if (r_cursor != csb_pkg::CNT_W'(csb_pkg::DEPTH)) begin
                        n_cursor = w_next_cur;
                    end
                end
                csb_pkg::ACT_INSERT: begin
                    if (w_full) begin
                        n_status = csb_pkg::ST_FULL;
                    end else begin
                        o_cmd.op  = csb_pkg::SH_INSERT;
                        o_cmd.pos = w_has ? r_cursor[csb_pkg::IDX_W-1:0] : '0;
                        n_cursor  = w_has ? r_cursor : '0;
                        n_count   = r_count + csb_pkg::CNT_W'(1);
                    end
                end
                csb_pkg::ACT_ATTACH: begin
                    if (w_full) begin
                        n_status = csb_pkg::ST_FULL;
                    end else begin
                        o_cmd.op  = csb_pkg::SH_INSERT;
                        o_cmd.pos = w_has ? w_next_cur[csb_pkg::IDX_W-1:0]
                                          : r_count[csb_pkg::IDX_W-1:0];
                        n_cursor  = w_has ? w_next_cur : r_count;
                        n_count   = r_count + csb_pkg::CNT_W'(1);
                    end
                end
                csb_pkg::ACT_REMOVE: begin
                    if (!w_has) begin
                        n_status = csb_pkg::ST_NO_CURRENT;
                    end else begin
                        o_cmd.op  = csb_pkg::SH_REMOVE;
                        o_cmd.pos = r_cursor[csb_pkg::IDX_W-1:0];
                        n_count   = r_count - csb_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    n_status = csb_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_strobe <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_info.strobe = r_strobe;
    assign o_info.status = r_status;
    assign o_info.count  = r_count;
    assign o_info.cursor = r_cursor;

endmodule
`default_nettype wire

### rtl/cursor_sequence_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core
// Ordered buffer with a cursor, built as a row of shifting entry cells.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// request   start / busy         i_action, i_value
// result    o_valid (strobe)     o_status, o_has_current, o_current_value,
//                                o_count, o_cursor_pos
//
// A request is taken in any cycle; busy stays low. All cells shift in the
// same cycle, so each result appears on the cycle after its request, one
// request per cycle sustained. Reset clears the count, the cursor and the
// strobe; entry contents are undefined until written. The receiver cannot
// stall, so no result is held.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [2:0]                i_action,
    input  wire logic [csb_pkg::WIDTH-1:0] i_value,
    output logic                           o_valid,
    output logic      [1:0]                o_status,
    output logic                           o_has_current,
    output logic      [csb_pkg::WIDTH-1:0] o_current_value,
    output logic      [csb_pkg::CNT_W-1:0] o_count,
    output logic      [csb_pkg::CNT_W-1:0] o_cursor_pos
);

    csb_pkg::t_shift_cmd   w_cmd;
    csb_pkg::t_result_info w_info;
    logic [csb_pkg::WIDTH-1:0] w_data [csb_pkg::DEPTH];
    logic w_has;

    assign busy = 1'b0;

    csb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_action (i_action),
        .o_cmd    (w_cmd),
        .o_info   (w_info)
    );

    for (genvar g = 0; g < csb_pkg::DEPTH; g++) begin : g_cell
        csb_cell u_cell (
            .i_clk   (i_clk),
            .i_index (csb_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_value (i_value),
            .i_left  ((g == 0) ? i_value : w_data[(g == 0) ? 0 : g - 1]),
            .i_right (w_data[(g == csb_pkg::DEPTH - 1) ? g : g + 1]),
            .o_data  (w_data[g])
        );
    end

    assign w_has           = w_info.cursor < w_info.count;
    assign o_valid         = w_info.strobe;
    assign o_status        = w_info.status;
    assign o_has_current   = w_has;
    assign o_current_value = w_has ? w_data[w_info.cursor[csb_pkg::IDX_W-1:0]] : '0;
    assign o_count         = w_info.count;
    assign o_cursor_pos    = w_info.cursor;

endmodule
`default_nettype wire

### dv/cursor_sequence_buffer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core_tb
// Self-checking bench for the cursor sequence buffer. A scoreboard keeps its
// own copy of the entries, the count and the cursor, predicts the reply to
// every accepted request and compares it field by field with each strobed
// result. Directed requests cover the edge cases, and random runs alternate
// between filling, draining and wandering phases with random gaps.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core_tb;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_ITEMS    = 700;
    localparam int         QUIET_TAIL      = 100;

    typedef struct {
        csb_pkg::t_status                 status;
        logic                             has_current;
        logic [csb_pkg::WIDTH-1:0]        current_value;
        logic [csb_pkg::CNT_W-1:0]        count;
        logic [csb_pkg::CNT_W-1:0]        cursor_pos;
    } t_reply;

    class csb_scoreboard;
        logic [csb_pkg::WIDTH-1:0] shadow_entries [csb_pkg::DEPTH];
        int               shadow_count;
        int               shadow_cursor;
        t_reply           pending_replies [$];
        int               mismatches;
        int               requests_seen;
        int               replies_seen;
        int               full_drops;
        int               empty_removes;
        int               saturations;

        function new();
            shadow_count  = 0;
            shadow_cursor = 0;
            mismatches    = 0;
            requests_seen = 0;
            replies_seen  = 0;
            full_drops    = 0;
            empty_removes = 0;
            saturations   = 0;
        endfunction

        function void note_request(logic [2:0] act, logic [csb_pkg::WIDTH-1:0] val);
            t_reply reply;
            bit     on_item;
            on_item      = shadow_cursor < shadow_count;
            reply.status = csb_pkg::ST_OK;
            case (act)
                csb_pkg::ACT_START: begin
                    shadow_cursor = 0;
                end
                csb_pkg::ACT_ADVANCE: begin
                    if (shadow_cursor < csb_pkg::DEPTH) shadow_cursor++;
                end
                csb_pkg::ACT_INSERT: begin
                    if (shadow_count >= csb_pkg::DEPTH) begin
                        reply.status = csb_pkg::ST_FULL;
                    end else begin
                        if (!on_item) shadow_cursor = 0;
                        for (int i = shadow_count; i > shadow_cursor; i--)
                            shadow_entries[i] = shadow_entries[i-1];
                        shadow_entries[shadow_cursor] = val;
                        shadow_count++;
                    end
                end
                csb_pkg::ACT_ATTACH: begin
                    if (shadow_count >= csb_pkg::DEPTH) begin
                        reply.status = csb_pkg::ST_FULL;
                    end else begin
                        if (on_item) begin
                            shadow_cursor++;
                            for (int i = shadow_count; i > shadow_cursor; i--)
                                shadow_entries[i] = shadow_entries[i-1];
                        end else begin
                            shadow_cursor = shadow_count;
                        end
                        shadow_entries[shadow_cursor] = val;
                        shadow_count++;
                    end
                end
                csb_pkg::ACT_REMOVE: begin
                    if (!on_item) begin
                        reply.status = csb_pkg::ST_NO_CURRENT;
                    end else begin
                        for (int i = shadow_cursor; i + 1 < shadow_count; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_count--;
                    end
                end
                default: begin
                end
            endcase
            on_item             = shadow_cursor < shadow_count;
            reply.has_current   = on_item;
            reply.current_value = on_item ? shadow_entries[shadow_cursor] : '0;
            reply.count         = csb_pkg::CNT_W'(shadow_count);
            reply.cursor_pos    = csb_pkg::CNT_W'(shadow_cursor);
            if (reply.status == csb_pkg::ST_FULL) full_drops++;
            if (reply.status == csb_pkg::ST_NO_CURRENT) empty_removes++;
            if (shadow_cursor == csb_pkg::DEPTH) saturations++;
            requests_seen++;
            pending_replies.push_back(reply);
        endfunction

        function void check_result(logic [1:0] status, logic has_current,
                                   logic [csb_pkg::WIDTH-1:0] current_value,
                                   logic [csb_pkg::CNT_W-1:0] count,
                                   logic [csb_pkg::CNT_W-1:0] cursor_pos);
            t_reply want;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                $error("Result strobe with no request outstanding.");
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (has_current !== want.has_current) begin
                $error("has_current: expected %0d, actual %0d",
                       want.has_current, has_current);
                mismatches++;
            end
            if (current_value !== want.current_value) begin
                $error("current_value: expected %h, actual %h",
                       want.current_value, current_value);
                mismatches++;
            end
            if (count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, count);
                mismatches++;
            end
            if (cursor_pos !== want.cursor_pos) begin
                $error("cursor_pos: expected %0d, actual %0d",
                       want.cursor_pos, cursor_pos);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [2:0]                i_action;
    logic [csb_pkg::WIDTH-1:0] i_value;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic                      o_has_current;
    logic [csb_pkg::WIDTH-1:0] o_current_value;
    logic [csb_pkg::CNT_W-1:0] o_count;
    logic [csb_pkg::CNT_W-1:0] o_cursor_pos;

    csb_scoreboard sb = new();

    cursor_sequence_buffer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_has_current   (o_has_current),
        .o_current_value (o_current_value),
        .o_count         (o_count),
        .o_cursor_pos    (o_cursor_pos)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results outstanding.", sb.pending_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_request(i_action, i_value);
            if (o_valid) begin
                sb.check_result(o_status, o_has_current, o_current_value,
                                o_count, o_cursor_pos);
            end
        end
    end

    task automatic send_request(input logic [2:0] act,
                                input logic [csb_pkg::WIDTH-1:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [csb_pkg::WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Mode 0 favors growth, mode 1 favors removal, mode 2 is even.
    function automatic logic [2:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 35) return csb_pkg::ACT_ATTACH;
                if (r < 65) return csb_pkg::ACT_INSERT;
                if (r < 78) return csb_pkg::ACT_ADVANCE;
                if (r < 86) return csb_pkg::ACT_START;
                if (r < 96) return csb_pkg::ACT_REMOVE;
            end
            1: begin
                if (r < 45) return csb_pkg::ACT_REMOVE;
                if (r < 57) return csb_pkg::ACT_START;
                if (r < 72) return csb_pkg::ACT_ADVANCE;
                if (r < 84) return csb_pkg::ACT_INSERT;
                if (r < 96) return csb_pkg::ACT_ATTACH;
            end
            default: begin
                if (r < 19) return csb_pkg::ACT_ATTACH;
                if (r < 38) return csb_pkg::ACT_INSERT;
                if (r < 57) return csb_pkg::ACT_ADVANCE;
                if (r < 76) return csb_pkg::ACT_REMOVE;
                if (r < 95) return csb_pkg::ACT_START;
            end
        endcase
        return 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    initial begin
        int issued;
        int burst;
        int mode;
        bit quiet;
        bit paused_once;

        start    = 1'b0;
        i_action = csb_pkg::ACT_START;
        i_value  = '0;
        i_rst_n  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(csb_pkg::ACT_REMOVE, 32'h1234_5678);
        send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_INSERT, '1);
        send_request(csb_pkg::ACT_ATTACH, '0);
        send_request(csb_pkg::ACT_START, '1);
        send_request(csb_pkg::ACT_INSERT, 32'hA5A5_A5A5);
        send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_REMOVE, '0);
        send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_ATTACH, 32'h5A5A_5A5A);
        for (int a = int'(ACT_SPARE_FIRST); a <= int'(ACT_SPARE_LAST); a++)
            send_request(3'(a), $urandom);
        send_request(csb_pkg::ACT_START, '0);
        while (sb.shadow_count < csb_pkg::DEPTH)
            send_request(csb_pkg::ACT_ATTACH, $urandom);
        send_request(csb_pkg::ACT_INSERT, $urandom);
        send_request(csb_pkg::ACT_ATTACH, $urandom);
        while (sb.shadow_cursor < csb_pkg::DEPTH) send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_ADVANCE, '0);
        send_request(csb_pkg::ACT_REMOVE, '0);
        send_request(csb_pkg::ACT_START, '0);
        send_request(csb_pkg::ACT_REMOVE, '0);

        issued      = 0;
        paused_once = 1'b0;
        while (issued < RANDOM_ITEMS) begin
            burst = $urandom_range(8, 40);
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0) || (issued >= RANDOM_ITEMS - QUIET_TAIL);
            for (int n = 0; n < burst && issued < RANDOM_ITEMS; n++) begin
                send_request(pick_action(mode), pick_value());
                issued++;
                if (!quiet && $urandom_range(0, 4) == 0)
                    pause_sender($urandom_range(1, 16));
            end
            if (!paused_once && issued >= RANDOM_ITEMS / 2) begin
                drain_replies();
                paused_once = 1'b1;
            end
        end

        drain_replies();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: %0d full drops,",
                 sb.requests_seen, sb.replies_seen, sb.full_drops);
        $display("%0d removes with no current item, %0d results at the saturated cursor.",
                 sb.empty_removes, sb.saturations);
        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
